@@ src/fuwag_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye unwarp address generator: shared definitions
// Register indexes, reset values, the sine table type and the function that
// builds the quarter-wave sine table at elaboration.
// ----------------------------------------------------------------------------
package fuwag_pkg;

  // Default parameter values.
  localparam int CoordBitsDef = 12;
  localparam int SineDepthDef = 1024;

  // Largest supported quarter-wave depth and the width of one table entry.
  localparam int MaxSineDepth = 4096;
  localparam int SineW        = 15;
  localparam int SineAmp      = 32767;

  // Configuration port widths.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgSrcWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOutWidth   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOutHeight  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPhaseStep  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAngleOfs   = 3'd5;

  // Register reset values.
  localparam logic [12:0] SrcWidthRst   = 13'd1920;
  localparam logic [12:0] SrcHeightRst  = 13'd1080;
  localparam logic [13:0] OutWidthRst   = 14'd1696;
  localparam logic [12:0] OutHeightRst  = 13'd540;
  localparam logic [23:0] PhaseStepRst  = 24'd9892;
  localparam logic [15:0] AngleOfsRst   = 16'd0;

  // pi/2 in Q30.
  localparam longint HalfPiQ30 = 64'sd1686629713;

  typedef logic [MaxSineDepth:0][SineW-1:0] sine_rom_t;

  // Quotient of two non-negative values by shift and subtract; only used
  // while the table is built at elaboration.
  function automatic longint udiv(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave sample, round(32767*sin(pi/2*k/depth)), from a Q30
  // Taylor series rounded half up.
  function automatic logic [SineW-1:0] quarter_sine(longint k, longint depth);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    x    = udiv(HalfPiQ30 * k, depth);
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >>> 30;
      term = udiv(term, longint'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * SineAmp + (64'sd1 <<< 29)) >>> 30;
    if (r > SineAmp) begin
      r = SineAmp;
    end
    return SineW'(r);
  endfunction

  // Full quarter-wave table; the entry at the depth itself is full scale and
  // entries beyond it are unused.
  function automatic sine_rom_t build_sine_table(int depth);
    sine_rom_t tab;
    tab = '0;
    for (int k = 0; k <= MaxSineDepth; k++) begin
      if (k < depth) begin
        tab[k] = quarter_sine(longint'(k), longint'(depth));
      end else if (k == depth) begin
        tab[k] = SineW'(SineAmp);
      end
    end
    return tab;
  endfunction

endpackage

@@ src/fuwag_phase.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase and table address stages
// Forms the column phase in turns, then the quarter-wave addresses and signs
// of the sine and the cosine.
// ----------------------------------------------------------------------------
module fuwag_phase #(
  parameter int SineTableDepth = fuwag_pkg::SineDepthDef,
  parameter int AddrBits       = $clog2(SineTableDepth) + 1
) (
  input  logic                clk_i,
  input  logic                ld_phase_i,
  input  logic                ld_addr_i,
  input  logic [12:0]         col_i,
  input  logic [23:0]         phase_step_i,
  input  logic [15:0]         angle_offset_i,
  output logic [AddrBits-1:0] sin_addr_o,
  output logic                sin_neg_o,
  output logic [AddrBits-1:0] cos_addr_o,
  output logic                cos_neg_o
);
  import fuwag_pkg::*;

  localparam int KBits   = $clog2(SineTableDepth);
  localparam int IdxBits = KBits + 2;

  logic [23:0]          col_ext;
  logic [23:0]          phase_d, phase_q;
  logic [IdxBits-1:0]   idx;
  logic [KBits-1:0]     k;
  logic [AddrBits-1:0]  k_ext;
  logic [AddrBits-1:0]  k_mirror;
  logic [1:0]           sin_quad, cos_quad;
  logic [AddrBits-1:0]  sin_addr_d, cos_addr_d;

  // Phase modulo one turn: the product keeps only its low 24 bits.
  assign col_ext = 24'(col_i);
  assign phase_d = col_ext * phase_step_i + {angle_offset_i, 8'b0};

  always_ff @(posedge clk_i) begin
    if (ld_phase_i) begin
      phase_q <= phase_d;
    end
  end

  // Quadrant and position inside the quadrant; the cosine is one quadrant on.
  assign idx      = phase_q[23 -: IdxBits];
  assign k        = idx[KBits-1:0];
  assign k_ext    = AddrBits'(k);
  assign k_mirror = AddrBits'(SineTableDepth) - k_ext;
  assign sin_quad = idx[IdxBits-1 -: 2];
  assign cos_quad = sin_quad + 2'd1;

  assign sin_addr_d = sin_quad[0] ? k_mirror : k_ext;
  assign cos_addr_d = cos_quad[0] ? k_mirror : k_ext;

  always_ff @(posedge clk_i) begin
    if (ld_addr_i) begin
      sin_addr_o <= sin_addr_d;
      sin_neg_o  <= sin_quad[1];
      cos_addr_o <= cos_addr_d;
      cos_neg_o  <= cos_quad[1];
    end
  end

endmodule

@@ src/fuwag_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table read at two addresses per cycle while ld_i is high, with
// registered data; the signs travel alongside the magnitudes.
// ----------------------------------------------------------------------------
module fuwag_sine_rom #(
  parameter int SineTableDepth = fuwag_pkg::SineDepthDef,
  parameter int AddrBits       = $clog2(SineTableDepth) + 1
) (
  input  logic                         clk_i,
  input  logic                         ld_i,
  input  logic [AddrBits-1:0]          sin_addr_i,
  input  logic                         sin_neg_i,
  input  logic [AddrBits-1:0]          cos_addr_i,
  input  logic                         cos_neg_i,
  output logic [fuwag_pkg::SineW-1:0]  sin_mag_o,
  output logic                         sin_neg_o,
  output logic [fuwag_pkg::SineW-1:0]  cos_mag_o,
  output logic                         cos_neg_o
);
  import fuwag_pkg::*;

  localparam sine_rom_t SineRom = build_sine_table(SineTableDepth);

  // Registered reads of both table ports.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      sin_mag_o <= SineRom[sin_addr_i];
      cos_mag_o <= SineRom[cos_addr_i];
      sin_neg_o <= sin_neg_i;
      cos_neg_o <= cos_neg_i;
    end
  end

endmodule

@@ src/fuwag_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source coordinate for one axis
// Computes trunc((size*32767 + 2*radius*s) / 65534) over four stages:
// product, sum and magnitude, division by 65534, range check and clamp.
// ----------------------------------------------------------------------------
module fuwag_axis #(
  parameter int CoordBits = fuwag_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic [3:0]                  ld_i,
  input  logic [11:0]                 radius_i,
  input  logic [fuwag_pkg::SineW-1:0] mag_i,
  input  logic                        neg_i,
  input  logic [12:0]                 size_i,
  output logic [CoordBits-1:0]        coord_o,
  output logic                        inside_o
);
  import fuwag_pkg::*;

  localparam logic [13:0] CoordMax = 14'((1 << CoordBits) - 1);

  logic [26:0]        prod_q;
  logic               prod_neg_q;
  logic [27:0]        base;
  logic [27:0]        term;
  logic signed [29:0] num;
  logic [28:0]        num_abs;
  logic [27:0]        half_q;
  logic               quot_neg_q;
  logic [12:0]        quot_est;
  logic [15:0]        rem;
  logic [13:0]        quot;
  logic signed [14:0] coord_d, coord_q;
  logic               inside_d;
  logic [CoordBits-1:0] clamp_d;

  // Radius times sine magnitude.
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      prod_q     <= 27'(radius_i) * 27'(mag_i);
      prod_neg_q <= neg_i;
    end
  end

  // Numerator with sign, then its magnitude halved: dividing by 65534 is
  // dividing the halved magnitude by 32767.
  assign base    = {size_i, 15'b0} - 28'(size_i);
  assign term    = {prod_q, 1'b0};
  assign num     = prod_neg_q ? ($signed({2'b0, base}) - $signed({2'b0, term}))
                              : ($signed({2'b0, base}) + $signed({2'b0, term}));
  assign num_abs = num[29] ? 29'(-num) : 29'(num);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      half_q     <= num_abs[28:1];
      quot_neg_q <= num[29];
    end
  end

  // Division by 32767: the shift estimate is low by at most one, so one
  // compare on the remainder corrects it.
  assign quot_est = half_q[27:15];
  assign rem      = 16'(half_q[14:0]) + 16'(quot_est);
  assign quot     = 14'(quot_est) + ((rem >= 16'(SineAmp)) ? 14'd1 : 14'd0);
  assign coord_d  = quot_neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      coord_q <= coord_d;
    end
  end

  // Range check against the image size and clamp to the coordinate range.
  assign inside_d = !coord_q[14] && (coord_q[13:0] < {1'b0, size_i});

  always_comb begin
    if (coord_q[14]) begin
      clamp_d = '0;
    end else if (coord_q[13:0] > CoordMax) begin
      clamp_d = CoordBits'(CoordMax);
    end else begin
      clamp_d = CoordBits'(coord_q[13:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      coord_o  <= clamp_d;
      inside_o <= inside_d;
    end
  end

endmodule

@@ src/fisheye_unwarp_address_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye unwarp address generator
// Maps each panorama pixel to the fisheye source pixel to sample, with the
// mirrored panorama position and an in-range flag.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_stall_o is low
// and returns one result per transaction, in order. A transaction passes
// through the seven pipeline stages: phase multiply, table address, sine
// table read, radius multiply, numerator sum, division by 65534 and the
// range check. A stall on the output holds every stage that is full and
// fills the bubbles in front of it, so the input stalls only when all seven
// stages hold results. The sine table is a constant and needs no start-up
// time. The user must write configuration only while no transaction is in
// flight; the block does not enforce it. cfg_ready_o is always high.
module fisheye_unwarp_address_gen #(
  parameter int CoordBits      = fuwag_pkg::CoordBitsDef,
  parameter int SineTableDepth = fuwag_pkg::SineDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fuwag_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fuwag_pkg::CfgDataW-1:0] cfg_data_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [12:0]                   dst_col_i,
  input  logic [11:0]                   dst_row_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CoordBits-1:0]          src_x_o,
  output logic [CoordBits-1:0]          src_y_o,
  output logic                          in_range_o,
  output logic [12:0]                   out_col_o,
  output logic [11:0]                   out_row_o
);
  import fuwag_pkg::*;

  localparam int AddrBits = $clog2(SineTableDepth) + 1;
  localparam int Stages   = 7;

  // Configuration registers.
  logic [12:0] src_width_q;
  logic [12:0] src_height_q;
  logic [13:0] out_width_q;
  logic [12:0] out_height_q;
  logic [23:0] phase_step_q;
  logic [15:0] angle_offset_q;

  // Pipeline control.
  logic [Stages:1]   v_q, v_d;
  logic [Stages:1]   v_prev;
  logic [Stages+1:1] rdy;

  // Side data travelling with each transaction.
  logic [11:0] row_q  [1:3];
  logic [12:0] ocol_q [1:Stages];
  logic [11:0] orow_q [1:Stages];
  logic [12:0] ocol_d;
  logic [11:0] orow_d;

  logic [AddrBits-1:0] sin_addr, cos_addr;
  logic                sin_neg_a, cos_neg_a;
  logic [SineW-1:0]    sin_mag, cos_mag;
  logic                sin_neg_r, cos_neg_r;
  logic                inside_x, inside_y;

  // Configuration writes; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= SrcWidthRst;
      src_height_q   <= SrcHeightRst;
      out_width_q    <= OutWidthRst;
      out_height_q   <= OutHeightRst;
      phase_step_q   <= PhaseStepRst;
      angle_offset_q <= AngleOfsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSrcWidth:  src_width_q    <= cfg_data_i[12:0];
        CfgSrcHeight: src_height_q   <= cfg_data_i[12:0];
        CfgOutWidth:  out_width_q    <= cfg_data_i[13:0];
        CfgOutHeight: out_height_q   <= cfg_data_i[12:0];
        CfgPhaseStep: phase_step_q   <= cfg_data_i[23:0];
        CfgAngleOfs:  angle_offset_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[Stages+1] = !out_stall_i;
    for (int i = Stages; i >= 1; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign v_prev     = {v_q[Stages-1:1], in_valid_i};
  assign v_d        = (rdy[Stages:1] & v_prev) | (~rdy[Stages:1] & v_q);
  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Mirrored panorama position, formed on entry.
  assign ocol_d = 13'(out_width_q - 14'd1 - {1'b0, dst_col_i});
  assign orow_d = 12'(out_height_q - 13'd1 - {1'b0, dst_row_i});

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      row_q[1]  <= dst_row_i;
      ocol_q[1] <= ocol_d;
      orow_q[1] <= orow_d;
    end
    for (int i = 2; i <= 3; i++) begin
      if (rdy[i]) begin
        row_q[i] <= row_q[i-1];
      end
    end
    for (int i = 2; i <= Stages; i++) begin
      if (rdy[i]) begin
        ocol_q[i] <= ocol_q[i-1];
        orow_q[i] <= orow_q[i-1];
      end
    end
  end

  // Phase and table addresses.
  fuwag_phase #(
    .SineTableDepth (SineTableDepth),
    .AddrBits       (AddrBits)
  ) u_phase (
    .clk_i          (clk_i),
    .ld_phase_i     (rdy[1]),
    .ld_addr_i      (rdy[2]),
    .col_i          (dst_col_i),
    .phase_step_i   (phase_step_q),
    .angle_offset_i (angle_offset_q),
    .sin_addr_o     (sin_addr),
    .sin_neg_o      (sin_neg_a),
    .cos_addr_o     (cos_addr),
    .cos_neg_o      (cos_neg_a)
  );

  // Sine and cosine magnitudes.
  fuwag_sine_rom #(
    .SineTableDepth (SineTableDepth),
    .AddrBits       (AddrBits)
  ) u_sine_rom (
    .clk_i      (clk_i),
    .ld_i       (rdy[3]),
    .sin_addr_i (sin_addr),
    .sin_neg_i  (sin_neg_a),
    .cos_addr_i (cos_addr),
    .cos_neg_i  (cos_neg_a),
    .sin_mag_o  (sin_mag),
    .sin_neg_o  (sin_neg_r),
    .cos_mag_o  (cos_mag),
    .cos_neg_o  (cos_neg_r)
  );

  // Horizontal source coordinate from the sine.
  fuwag_axis #(
    .CoordBits (CoordBits)
  ) u_axis_x (
    .clk_i    (clk_i),
    .ld_i     (rdy[7:4]),
    .radius_i (row_q[3]),
    .mag_i    (sin_mag),
    .neg_i    (sin_neg_r),
    .size_i   (src_width_q),
    .coord_o  (src_x_o),
    .inside_o (inside_x)
  );

  // Vertical source coordinate from the cosine.
  fuwag_axis #(
    .CoordBits (CoordBits)
  ) u_axis_y (
    .clk_i    (clk_i),
    .ld_i     (rdy[7:4]),
    .radius_i (row_q[3]),
    .mag_i    (cos_mag),
    .neg_i    (cos_neg_r),
    .size_i   (src_height_q),
    .coord_o  (src_y_o),
    .inside_o (inside_y)
  );

  // Output stage.
  assign out_valid_o = v_q[Stages];
  assign in_range_o  = inside_x && inside_y;
  assign out_col_o   = ocol_q[Stages];
  assign out_row_o   = orow_q[Stages];

`ifndef ASSERT_OFF
  // The input stalls only when every stage holds a transaction.
  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (&v_q)
  ) else $error("input stalled while the pipeline has a free stage");

  // An accepted transaction lands in the first stage.
  a_accept_enters: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && !in_stall_o) |=> v_q[1]
  ) else $error("accepted transaction did not enter the pipeline");

  // A held stage keeps its transaction.
  a_hold_mid_stage: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (v_q[4] && !rdy[5]) |=> v_q[4]
  ) else $error("transaction lost in a stalled stage");

  // An in-range result lies inside the source image.
  a_in_range_bounds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && in_range_o) |-> (src_x_o < src_width_q) && (src_y_o < src_height_q)
  ) else $error("in-range result outside the source image");
`endif

endmodule

@@ bench/fisheye_unwarp_address_gen_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye unwarp address generator testbench
// Drives destination pixels into the block across a series of register
// settings and idling patterns. A scoreboard predicts every sample address
// from its own sine table and fixed-point arithmetic and compares each
// result with the oldest expected one.
// ----------------------------------------------------------------------------
module fisheye_unwarp_address_gen_test;

  import fuwag_pkg::*;

  localparam int CoordBits = CoordBitsDef;
  localparam int SineDepth = SineDepthDef;
  localparam int ClkHalf   = 4;
  localparam int RandItems = 142;
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 400000;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  // Idling patterns.
  localparam int IdleNone = 0;
  localparam int IdleSend = 1;
  localparam int IdleRecv = 2;
  localparam int IdleBoth = 3;

  typedef struct {
    logic [CoordBits-1:0] src_x;
    logic [CoordBits-1:0] src_y;
    logic                 in_range;
    logic [12:0]          out_col;
    logic [11:0]          out_row;
  } sample_addr_t;

  // Predicts the sample address of each accepted pixel and checks results
  // against the queue of expected addresses.
  class unwarp_scoreboard;
    int          sine_lut[SineDepth+1];
    longint      src_w;
    longint      src_h;
    longint      pano_w;
    longint      pano_h;
    longint      step;
    longint      ofs;
    sample_addr_t pending_addrs[$];
    int unsigned faults;
    int unsigned checked;
    int unsigned inside_seen;
    int unsigned outside_seen;

    function new();
      for (int k = 0; k < SineDepth; k++) begin
        sine_lut[k] = wave_sample(k);
      end
      sine_lut[SineDepth] = SineAmp;
      src_w  = SrcWidthRst;
      src_h  = SrcHeightRst;
      pano_w = OutWidthRst;
      pano_h = OutHeightRst;
      step   = PhaseStepRst;
      ofs    = AngleOfsRst;
      faults = 0;
      checked = 0;
      inside_seen = 0;
      outside_seen = 0;
    endfunction

    // Quarter-wave sample scaled by 32767, Q30 Taylor series rounded half up.
    function int wave_sample(longint k);
      longint ang;
      longint ang2;
      longint term;
      longint acc;
      longint r;
      int     n;
      ang  = HalfPiQ30 * k / SineDepth;
      ang2 = (ang * ang) >>> 30;
      term = ang;
      acc  = ang;
      for (n = 1; n <= 7; n++) begin
        term = (term * ang2) >>> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (acc * SineAmp + (64'sd1 <<< 29)) >>> 30;
      if (r > SineAmp) begin
        r = SineAmp;
      end
      return int'(r);
    endfunction

    // Full-wave sine from the quarter table.
    function longint wave_at(longint idx);
      longint quad;
      longint k;
      quad = (idx / SineDepth) % 4;
      k    = idx % SineDepth;
      case (quad)
        0: return sine_lut[k];
        1: return sine_lut[SineDepth-k];
        2: return -sine_lut[k];
        default: return -sine_lut[SineDepth-k];
      endcase
    endfunction

    function logic [CoordBits-1:0] clamp_coord(longint v);
      longint top;
      top = (64'sd1 <<< CoordBits) - 1;
      if (v < 0) begin
        return '0;
      end
      if (v > top) begin
        return CoordBits'(top);
      end
      return CoordBits'(v);
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgSrcWidth:  src_w  = longint'(data[12:0]);
        CfgSrcHeight: src_h  = longint'(data[12:0]);
        CfgOutWidth:  pano_w = longint'(data[13:0]);
        CfgOutHeight: pano_h = longint'(data[12:0]);
        CfgPhaseStep: step   = longint'(data[23:0]);
        CfgAngleOfs:  ofs    = longint'(data[15:0]);
        default: ;
      endcase
    endfunction

    // Works out the sample address of one accepted pixel.
    function void note_pixel(logic [12:0] col, logic [11:0] row);
      longint       ph;
      longint       idx;
      longint       sn;
      longint       cs;
      longint       px;
      longint       py;
      sample_addr_t want;
      ph  = (longint'(col) * step + (ofs << 8)) & 64'hFFFFFF;
      idx = (ph * 4 * SineDepth) >>> 24;
      sn  = wave_at(idx);
      cs  = wave_at((idx + SineDepth) % (4 * SineDepth));
      px  = (src_w * 32767 + 2 * longint'(row) * sn) / 65534;
      py  = (src_h * 32767 + 2 * longint'(row) * cs) / 65534;
      want.src_x    = clamp_coord(px);
      want.src_y    = clamp_coord(py);
      want.in_range = (px >= 0 && py >= 0 && px < src_w && py < src_h);
      want.out_col  = 13'(pano_w - 1 - longint'(col));
      want.out_row  = 12'(pano_h - 1 - longint'(row));
      pending_addrs.insert(pending_addrs.size(), want);
    endfunction

    function void check_address(logic [CoordBits-1:0] x, logic [CoordBits-1:0] y,
                                logic inr, logic [12:0] oc, logic [11:0] orow);
      sample_addr_t want;
      if (pending_addrs.size() == 0) begin
        $error("unexpected result: src_x %0d src_y %0d with nothing expected", x, y);
        faults++;
        return;
      end
      want = pending_addrs.pop_front();
      checked++;
      if (want.in_range) begin
        inside_seen++;
      end else begin
        outside_seen++;
      end
      if (x !== want.src_x) begin
        $error("src_x mismatch: expected %0d, actual %0d", want.src_x, x);
        faults++;
      end
      if (y !== want.src_y) begin
        $error("src_y mismatch: expected %0d, actual %0d", want.src_y, y);
        faults++;
      end
      if (inr !== want.in_range) begin
        $error("in_range mismatch: expected %0d, actual %0d", want.in_range, inr);
        faults++;
      end
      if (oc !== want.out_col) begin
        $error("out_col mismatch: expected %0d, actual %0d", want.out_col, oc);
        faults++;
      end
      if (orow !== want.out_row) begin
        $error("out_row mismatch: expected %0d, actual %0d", want.out_row, orow);
        faults++;
      end
    endfunction

    function int pending();
      return pending_addrs.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [12:0]          dst_col_i;
  logic [11:0]          dst_row_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CoordBits-1:0] src_x_o;
  logic [CoordBits-1:0] src_y_o;
  logic                 in_range_o;
  logic [12:0]          out_col_o;
  logic [11:0]          out_row_o;

  unwarp_scoreboard sb;
  int unsigned      cycle_count;
  int               idle_mode;
  bit               hold_req;
  int unsigned      pixels_sent;
  int unsigned      settings_used;

  fisheye_unwarp_address_gen #(
    .CoordBits      (CoordBits),
    .SineTableDepth (SineDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dst_col_i   (dst_col_i),
    .dst_row_i   (dst_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .in_range_o  (in_range_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a run that outlasts the limit has hung.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("fisheye_unwarp_address_gen_test failed");
    $finish;
  end

  // Receiver: random stalls by idling pattern, plus a long counted hold-off.
  initial begin
    int hold_left;
    int pct;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      pct = (idle_mode == IdleRecv) ? 66 : (idle_mode == IdleBoth) ? 24 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Result monitor: every accepted transaction on the output is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_address(src_x_o, src_y_o, in_range_o, out_col_o, out_row_o);
    end
  end

  // Offers one pixel, with random idle cycles first, and waits for acceptance.
  task automatic send_pixel(input logic [12:0] col, input logic [11:0] row);
    int pct;
    pct = (idle_mode == IdleSend) ? 66 : (idle_mode == IdleBoth) ? 24 : 0;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dst_col_i  <= col;
    dst_row_i  <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(col, row);
    pixels_sent++;
  endtask

  // Drops the input valid and waits until every expected address is back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_view(input int unsigned sw, input int unsigned sh,
                              input int unsigned ow, input int unsigned oh,
                              input int unsigned stp, input int unsigned aofs);
    write_reg(CfgSrcWidth,  CfgDataW'(sw));
    write_reg(CfgSrcHeight, CfgDataW'(sh));
    write_reg(CfgOutWidth,  CfgDataW'(ow));
    write_reg(CfgOutHeight, CfgDataW'(oh));
    write_reg(CfgPhaseStep, CfgDataW'(stp));
    write_reg(CfgAngleOfs,  CfgDataW'(aofs));
    settings_used++;
  endtask

  // Random pixel: mostly inside the panorama with radii that land inside
  // the source, the rest anywhere in the field ranges.
  task automatic send_random_pixel();
    logic [12:0] col;
    logic [11:0] row;
    longint      rmax;
    longint      cmax;
    if ($urandom_range(0, 99) < 60) begin
      cmax = (sb.pano_w > 0) ? sb.pano_w - 1 : 0;
      if (cmax > 8191) cmax = 8191;
      rmax = ((sb.src_w < sb.src_h) ? sb.src_w : sb.src_h) / 2 + 2;
      if (rmax > 4095) rmax = 4095;
      col = 13'($urandom_range(0, int'(cmax)));
      row = 12'($urandom_range(0, int'(rmax)));
    end else begin
      col = 13'($urandom_range(0, 8191));
      row = 12'($urandom_range(0, 4095));
    end
    send_pixel(col, row);
  endtask

  // Main sequence.
  initial begin
    int phase_mode[8];
    int ph;
    sb          = new();
    idle_mode   = IdleNone;
    hold_req    = 1'b0;
    pixels_sent = 0;
    settings_used = 1;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    dst_col_i   = '0;
    dst_row_i   = '0;
    phase_mode  = '{IdleNone, IdleSend, IdleRecv, IdleBoth, IdleSend, IdleRecv,
                    IdleNone, IdleBoth};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: field extremes, the panorama corner and wrapping.
    send_pixel(13'd0, 12'd0);
    send_pixel(13'd8191, 12'd4095);
    send_pixel(13'd1695, 12'd539);
    send_pixel(13'd1696, 12'd540);
    send_pixel(13'd4095, 12'd2048);
    send_pixel(13'd0, 12'd4095);
    send_pixel(13'd212, 12'd300);
    drain();

    // One-pixel source looking at three-quarter turn: a coordinate just
    // below zero truncates to zero and still counts as inside. Writes to
    // indexes without a register must change nothing.
    program_view(1, 1, 1, 1, 0, 16'hC000);
    write_reg(CfgSpareA, CfgDataW'($urandom));
    write_reg(CfgSpareB, CfgDataW'($urandom));
    send_pixel(13'd0, 12'd1);
    send_pixel(13'd0, 12'd0);
    send_pixel(13'd8191, 12'd4095);
    drain();

    // Zero source size never reports a point inside.
    program_view(0, 0, 1696, 540, 9892, 0);
    send_pixel(13'd5, 12'd0);
    drain();

    // Quarter turn per column on the largest source, with clamping at both
    // ends of the coordinate range.
    program_view(4096, 4096, 8192, 4096, 24'h400000, 0);
    send_pixel(13'd0, 12'd2047);
    send_pixel(13'd1, 12'd2047);
    send_pixel(13'd2, 12'd2047);
    send_pixel(13'd3, 12'd2047);
    send_pixel(13'd0, 12'd4095);
    send_pixel(13'd3, 12'd4095);
    drain();

    // Random phases over a series of settings and idling patterns.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_view(SrcWidthRst, SrcHeightRst, OutWidthRst, OutHeightRst,
                        PhaseStepRst, AngleOfsRst);
        1: program_view(4096, 4096, 8192, 4096, 24'hFFFFFF, 16'hFFFF);
        2: program_view(1, 1, 1, 1, 0, 0);
        5: program_view(640, 480, 1696, 540, $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
        default: program_view($urandom_range(1, 4096), $urandom_range(1, 4096),
                              $urandom_range(1, 8192), $urandom_range(1, 4096),
                              $urandom & 24'hFFFFFF, $urandom_range(0, 65535));
      endcase
      write_reg(CfgSpareA, CfgDataW'($urandom));
      idle_mode = phase_mode[ph];
      for (int i = 0; i < RandItems; i++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (ph == 0 && i == 40) begin
          hold_req = 1'b1;
        end
        // Sender pauses until every expected address has come back.
        if (ph == 4 && i == 70) begin
          drain();
        end
        send_random_pixel();
      end
      drain();
    end

    idle_mode = IdleNone;
    repeat (16) @(posedge clk_i);

    $display("Covered %0d pixels over %0d register settings and four idling patterns.",
             pixels_sent, settings_used);
    $display("Checked %0d sample addresses: %0d inside the source, %0d outside.",
             sb.checked, sb.inside_seen, sb.outside_seen);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("fisheye_unwarp_address_gen_test passed");
    end else begin
      $display("fisheye_unwarp_address_gen_test failed");
    end
    $finish;
  end

endmodule
